### design/dwpi_pkg.sv
// Shared widths, register indexes and operand sizes of the dual-wheel PI velocity controller.
package dwpi_pkg;

    localparam int TARGET_W  = 12;
    localparam int SCALE_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 9;
    localparam int EFFORT_W  = 10;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // The multiplier's second operand is an unsigned gain or scale with a zero sign bit.
    localparam int MUL_B_W   = GAIN_W + 1;

    // The integral enters the multiplier clamped to plus or minus 2^32.
    // Past that bound the proportional term cannot change the sign or the clamped effort.
    localparam int ICAP_W    = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFORT_LIMIT = 3'd5;

endpackage

### design/dwpi_mul.sv
// Shared signed multiplier with a registered product.
module dwpi_mul #(
    parameter int A_W = 34
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [A_W-1:0]              a,
    input  logic signed [dwpi_pkg::MUL_B_W-1:0] b,
    output logic signed [A_W+dwpi_pkg::MUL_B_W-1:0] prod
);
    import dwpi_pkg::*;

    logic signed [A_W+MUL_B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

### design/dual_wheel_pi_velocity_control.sv
// Top level of the dual-wheel PI velocity controller with encoder speed measurement.
// A new input word is taken only when the sequencer is idle; the single shared multiplier
// runs three products per wheel and the sequencer handles the left wheel, then the right wheel.
// A stalled output word holds the sequencer in its final step until it is taken.
// Reset clears the last counts and integrals to zero and loads the register defaults.
module dual_wheel_pi_velocity_control #(
    parameter int COUNT_WIDTH = 16,
    parameter int SUM_WIDTH   = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COUNT_WIDTH-1:0]          enc_count_left,
    input  logic signed [COUNT_WIDTH-1:0]          enc_count_right,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [dwpi_pkg::EFFORT_W-1:0]   effort_left,
    output logic signed [dwpi_pkg::EFFORT_W-1:0]   effort_right,
    output logic signed [dwpi_pkg::SPEED_W-1:0]    speed_left,
    output logic signed [dwpi_pkg::SPEED_W-1:0]    speed_right,
    input  logic                                   cfg_write,
    input  logic [dwpi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dwpi_pkg::CFG_DAT_W-1:0]         cfg_data
);
    import dwpi_pkg::*;

    localparam int AW  = (COUNT_WIDTH > ICAP_W) ? COUNT_WIDTH : ICAP_W;
    localparam int PW  = AW + MUL_B_W;
    localparam int TW  = PW + 1;
    localparam int SCW = (SUM_WIDTH > ICAP_W) ? SUM_WIDTH : ICAP_W;
    localparam int SW1 = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL_SPD = 3'd1;
    localparam logic [2:0] ST_SPEED   = 3'd2;
    localparam logic [2:0] ST_MUL_P   = 3'd3;
    localparam logic [2:0] ST_MUL_I   = 3'd4;
    localparam logic [2:0] ST_ADD     = 3'd5;
    localparam logic [2:0] ST_EFFORT  = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    localparam logic signed [SCW-1:0] ICAP_HI = SCW'({2'b01, {(ICAP_W-2){1'b0}}});
    localparam logic signed [SCW-1:0] ICAP_LO = -ICAP_HI;
    localparam logic signed [PW-9:0]  SPD_MAX = (PW-8)'(32767);
    localparam logic signed [PW-9:0]  SPD_MIN = (PW-8)'(-32768);
    localparam logic signed [SW1-1:0] SUM_MAX = SW1'({1'b0, {(SUM_WIDTH-1){1'b1}}});
    localparam logic signed [SW1-1:0] SUM_MIN = ~SUM_MAX;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic                         wheel_reg;
    logic                         out_valid_reg;

    logic signed [TARGET_W-1:0]   tgt_l_reg;
    logic signed [TARGET_W-1:0]   tgt_r_reg;
    logic [SCALE_W-1:0]           scale_reg;
    logic [GAIN_W-1:0]            prop_reg;
    logic [GAIN_W-1:0]            integ_reg;
    logic [LIMIT_W-1:0]           lim_reg;

    logic [COUNT_WIDTH-1:0]       last_reg [2];
    logic signed [SUM_WIDTH-1:0]  sum_reg [2];

    logic [COUNT_WIDTH-1:0]       cnt_l_reg;
    logic [COUNT_WIDTH-1:0]       cnt_r_reg;
    logic signed [ERR_W-1:0]      err_reg;
    logic signed [PW-1:0]         acc_reg;
    logic signed [TW-1:0]         tot_reg;
    logic signed [SPEED_W-1:0]    spd_l_reg;
    logic signed [SPEED_W-1:0]    spd_r_reg;
    logic signed [EFFORT_W-1:0]   eff_l_reg;
    logic signed [EFFORT_W-1:0]   eff_r_reg;
    logic signed [EFFORT_W-1:0]   out_eff_l_reg;
    logic signed [EFFORT_W-1:0]   out_eff_r_reg;
    logic signed [SPEED_W-1:0]    out_spd_l_reg;
    logic signed [SPEED_W-1:0]    out_spd_r_reg;

    logic                         in_acc;
    logic                         out_load;
    logic [COUNT_WIDTH-1:0]       cnt_sel;
    logic signed [COUNT_WIDTH-1:0] delta;
    logic signed [SUM_WIDTH-1:0]  sum_sel;
    logic signed [TARGET_W-1:0]   tgt_sel;
    logic signed [SCW-1:0]        sum_ext;
    logic signed [SCW-1:0]        sum_cap;
    logic                         mul_en;
    logic signed [AW-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         prod_bias;
    logic signed [PW-9:0]         spd_q;
    logic signed [SPEED_W-1:0]    spd_sat;
    logic signed [ERR_W-1:0]      err;
    logic signed [TW-1:0]         tot_bias;
    logic signed [TW-9:0]         tot_q;
    logic signed [TW-9:0]         lim_ext;
    logic signed [TW-9:0]         eff_c;
    logic signed [SW1-1:0]        sum_add;
    logic signed [SUM_WIDTH-1:0]  sum_sat;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign cnt_sel = wheel_reg ? cnt_r_reg : cnt_l_reg;
    assign delta   = $signed(cnt_sel - last_reg[wheel_reg]);
    assign sum_sel = sum_reg[wheel_reg];
    assign tgt_sel = wheel_reg ? tgt_r_reg : tgt_l_reg;

    always_comb
    begin
        sum_ext = SCW'(sum_sel);
        if (sum_ext > ICAP_HI)
        begin
            sum_cap = ICAP_HI;
        end
        else if (sum_ext < ICAP_LO)
        begin
            sum_cap = ICAP_LO;
        end
        else
        begin
            sum_cap = sum_ext;
        end
    end

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = AW'(delta);
        mul_b  = $signed({1'b0, scale_reg});
        case (state_reg)
            ST_MUL_SPD:
            begin
                mul_en = 1'b1;
            end
            ST_MUL_P:
            begin
                mul_en = 1'b1;
                mul_a  = AW'(err_reg);
                mul_b  = $signed({1'b0, prop_reg});
            end
            ST_MUL_I:
            begin
                mul_en = 1'b1;
                mul_a  = AW'(sum_cap);
                mul_b  = $signed({1'b0, integ_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    dwpi_mul #(
        .A_W (AW)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Division by 256 truncates toward zero, so negative values get a bias first.
    always_comb
    begin
        prod_bias = prod + (prod[PW-1] ? PW'(8'hff) : '0);
        spd_q     = $signed(prod_bias[PW-1:8]);
        if (spd_q > SPD_MAX)
        begin
            spd_sat = SPEED_W'(SPD_MAX);
        end
        else if (spd_q < SPD_MIN)
        begin
            spd_sat = SPEED_W'(SPD_MIN);
        end
        else
        begin
            spd_sat = SPEED_W'(spd_q);
        end
        err = ERR_W'(tgt_sel) - ERR_W'(spd_sat);
    end

    always_comb
    begin
        tot_bias = tot_reg + (tot_reg[TW-1] ? TW'(8'hff) : '0);
        tot_q    = $signed(tot_bias[TW-1:8]);
        lim_ext  = (TW-8)'($signed({1'b0, lim_reg}));
        if (tot_q > lim_ext)
        begin
            eff_c = lim_ext;
        end
        else if (tot_q < -lim_ext)
        begin
            eff_c = -lim_ext;
        end
        else
        begin
            eff_c = tot_q;
        end
    end

    always_comb
    begin
        sum_add = SW1'(sum_sel) + SW1'(err_reg);
        if (sum_add > SUM_MAX)
        begin
            sum_sat = SUM_WIDTH'(SUM_MAX);
        end
        else if (sum_add < SUM_MIN)
        begin
            sum_sat = SUM_WIDTH'(SUM_MIN);
        end
        else
        begin
            sum_sat = SUM_WIDTH'(sum_add);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_MUL_SPD;
                end
            end
            ST_MUL_SPD: state_next = ST_SPEED;
            ST_SPEED:   state_next = ST_MUL_P;
            ST_MUL_P:   state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_ADD;
            ST_ADD:     state_next = ST_EFFORT;
            ST_EFFORT:
            begin
                state_next = wheel_reg ? ST_DONE : ST_MUL_SPD;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            tgt_l_reg     <= '0;
            tgt_r_reg     <= '0;
            scale_reg     <= SCALE_W'(256);
            prop_reg      <= GAIN_W'(256);
            integ_reg     <= '0;
            lim_reg       <= LIMIT_W'(300);
            for (int i = 0; i < 2; i++)
            begin
                last_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (in_acc)
            begin
                wheel_reg <= 1'b0;
            end
            else if (state_reg == ST_EFFORT)
            begin
                wheel_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TARGET_LEFT:  tgt_l_reg <= $signed(cfg_data[TARGET_W-1:0]);
                    CFG_TARGET_RIGHT: tgt_r_reg <= $signed(cfg_data[TARGET_W-1:0]);
                    CFG_SPEED_SCALE:  scale_reg <= cfg_data[SCALE_W-1:0];
                    CFG_PROP_GAIN:    prop_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:   integ_reg <= cfg_data[GAIN_W-1:0];
                    CFG_EFFORT_LIMIT: lim_reg   <= cfg_data[LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_acc && restart)
            begin
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
            end
            else if (state_reg == ST_EFFORT)
            begin
                sum_reg[wheel_reg] <= sum_sat;
            end

            if (state_reg == ST_MUL_SPD)
            begin
                last_reg[wheel_reg] <= cnt_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cnt_l_reg <= enc_count_left;
            cnt_r_reg <= enc_count_right;
        end
        if (state_reg == ST_SPEED)
        begin
            err_reg <= err;
            if (wheel_reg)
            begin
                spd_r_reg <= spd_sat;
            end
            else
            begin
                spd_l_reg <= spd_sat;
            end
        end
        if (state_reg == ST_MUL_I)
        begin
            acc_reg <= prod;
        end
        if (state_reg == ST_ADD)
        begin
            tot_reg <= TW'(acc_reg) + TW'(prod);
        end
        if (state_reg == ST_EFFORT)
        begin
            if (wheel_reg)
            begin
                eff_r_reg <= eff_c[EFFORT_W-1:0];
            end
            else
            begin
                eff_l_reg <= eff_c[EFFORT_W-1:0];
            end
        end
        if (out_load)
        begin
            out_eff_l_reg <= eff_l_reg;
            out_eff_r_reg <= eff_r_reg;
            out_spd_l_reg <= spd_l_reg;
            out_spd_r_reg <= spd_r_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign effort_left  = out_eff_l_reg;
    assign effort_right = out_eff_r_reg;
    assign speed_left   = out_spd_l_reg;
    assign speed_right  = out_spd_r_reg;

    // An accepted word always starts with the left wheel.
    a_start_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_MUL_SPD) && !wheel_reg)
        else $error("accepted word did not start on the left wheel");

    // A restart clears both integrals before any wheel is processed.
    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && restart) |=> (sum_reg[0] == '0) && (sum_reg[1] == '0))
        else $error("restart did not clear the integrals");

    // A delivered effort never exceeds the configured limit in magnitude.
    a_effort_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_eff_l_reg) <= $signed({1'b0, lim_reg}))
            && ($signed(out_eff_l_reg) >= -$signed({1'b0, lim_reg}))
            && ($signed(out_eff_r_reg) <= $signed({1'b0, lim_reg}))
            && ($signed(out_eff_r_reg) >= -$signed({1'b0, lim_reg})))
        else $error("effort word outside the effort limit");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the dual-wheel PI velocity controller: directed and random ticks.
module tb_top;
    import dwpi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam longint ITERM_CAP = longint'(1) << 40;
    localparam longint SUM_MAX   = (longint'(1) << 31) - 1;
    localparam longint SUM_MIN   = -(longint'(1) << 31);

    localparam int RANDOM_PHASES   = 9;
    localparam int TICKS_PER_PHASE = 215;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int TAIL_CYCLES     = 40;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        logic signed [EFFORT_W-1:0] effort_left;
        logic signed [EFFORT_W-1:0] effort_right;
        logic signed [SPEED_W-1:0]  speed_left;
        logic signed [SPEED_W-1:0]  speed_right;
    } control_word_t;

    class tick_scoreboard;
        longint        target_speed[2];
        longint        speed_scale;
        longint        prop_gain;
        longint        integ_gain;
        longint        effort_limit;
        logic [15:0]   last_count[2];
        longint        error_sum[2];
        control_word_t expected_words[$];
        int            failures;

        function new();
            target_speed[0] = 0;
            target_speed[1] = 0;
            speed_scale = 256;
            prop_gain = 256;
            integ_gain = 0;
            effort_limit = 300;
            last_count[0] = '0;
            last_count[1] = '0;
            error_sum[0] = 0;
            error_sum[1] = 0;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_TARGET_LEFT:  target_speed[0] = longint'($signed(data[TARGET_W-1:0]));
                CFG_TARGET_RIGHT: target_speed[1] = longint'($signed(data[TARGET_W-1:0]));
                CFG_SPEED_SCALE:  speed_scale = longint'(data[SCALE_W-1:0]);
                CFG_PROP_GAIN:    prop_gain = longint'(data[GAIN_W-1:0]);
                CFG_INTEG_GAIN:   integ_gain = longint'(data[GAIN_W-1:0]);
                CFG_EFFORT_LIMIT: effort_limit = longint'(data[LIMIT_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint trunc_q8(longint p);
            if (p >= 0)
                return p >>> 8;
            return -((-p) >>> 8);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void control_wheel(int w, logic [15:0] count,
                                    output longint speed, output longint effort);
            logic [15:0] step;
            longint      delta;
            longint      err;
            longint      iterm;
            step = count - last_count[w];
            delta = longint'($signed(step));
            last_count[w] = count;
            speed = clamp(trunc_q8(delta * speed_scale), -32768, 32767);
            err = target_speed[w] - speed;
            iterm = clamp(integ_gain * error_sum[w], -ITERM_CAP, ITERM_CAP);
            effort = clamp(trunc_q8(prop_gain * err + iterm), -effort_limit, effort_limit);
            error_sum[w] = clamp(error_sum[w] + err, SUM_MIN, SUM_MAX);
        endfunction

        function void note_tick(logic [15:0] left_enc, logic [15:0] right_enc,
                                logic clear_sums);
            control_word_t w;
            longint        sl;
            longint        el;
            longint        sr;
            longint        er;
            if (clear_sums)
            begin
                error_sum[0] = 0;
                error_sum[1] = 0;
            end
            control_wheel(0, left_enc, sl, el);
            control_wheel(1, right_enc, sr, er);
            w.effort_left = el[EFFORT_W-1:0];
            w.effort_right = er[EFFORT_W-1:0];
            w.speed_left = sl[SPEED_W-1:0];
            w.speed_right = sr[SPEED_W-1:0];
            expected_words.push_back(w);
        endfunction

        function void compare_field(string field, logic signed [15:0] want,
                                    logic signed [15:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, actual %0d", field, want, seen);
                failures++;
            end
        endfunction

        function void check_result(control_word_t got);
            control_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word arrived with no tick outstanding");
                failures++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("effort_left", want.effort_left, got.effort_left);
            compare_field("effort_right", want.effort_right, got.effort_right);
            compare_field("speed_left", want.speed_left, got.speed_left);
            compare_field("speed_right", want.speed_right, got.speed_right);
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [15:0]           enc_count_left;
    logic signed [15:0]           enc_count_right;
    logic                         restart;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [EFFORT_W-1:0]   effort_left;
    logic signed [EFFORT_W-1:0]   effort_right;
    logic signed [SPEED_W-1:0]    speed_left;
    logic signed [SPEED_W-1:0]    speed_right;
    logic                         cfg_write;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DAT_W-1:0]         cfg_data;
    logic                         pressure_on;

    tick_scoreboard sb = new();

    dual_wheel_pi_velocity_control dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .enc_count_left  (enc_count_left),
        .enc_count_right (enc_count_right),
        .restart         (restart),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .effort_left     (effort_left),
        .effort_right    (effort_right),
        .speed_left      (speed_left),
        .speed_right     (speed_right),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12_000_000);
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin : result_monitor
        control_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.effort_left = effort_left;
            got.effort_right = effort_right;
            got.speed_left = speed_left;
            got.speed_right = speed_right;
            sb.check_result(got);
        end
    end

    initial
    begin : receiver
        stall_mode_t mode;
        int          len;
        int          beat;
        bit          held;
        out_stall <= 1'b0;
        held = 1'b0;
        beat = 0;
        forever
        begin
            if (pressure_on && !held)
            begin
                held = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode = stall_mode_t'($urandom_range(0, 3));
            len = $urandom_range(20, 200);
            repeat (len)
            begin
                @(posedge clk);
                beat++;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ((beat % 7) < 3);
                endcase
            end
        end
    end

    task automatic send_tick(input logic [15:0] left_enc, input logic [15:0] right_enc,
                             input logic clear_sums);
        in_valid <= 1'b1;
        enc_count_left <= left_enc;
        enc_count_right <= right_enc;
        restart <= clear_sums;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_tick(left_enc, right_enc, clear_sums);
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    function automatic logic [15:0] choose_setting(int phase, logic [15:0] lowest,
                                                   logic [15:0] highest, logic [15:0] typical,
                                                   int width);
        logic [31:0] keep;
        logic [15:0] v;
        int          sel;
        sel = (phase == 0) ? 1 : (phase == 1) ? 0 : $urandom_range(0, 5);
        v = (sel == 0) ? lowest : (sel == 1) ? highest : typical;
        keep = (32'h1 << width) - 1;
        return 16'((v & keep) | ($urandom_range(0, 65535) & ~keep));
    endfunction

    function automatic int pick_velocity();
        case ($urandom_range(0, 2))
            0:       return int'($urandom_range(0, 80)) - 40;
            1:       return int'($urandom_range(0, 3000)) - 1500;
            default: return int'($urandom_range(0, 60000)) - 30000;
        endcase
    endfunction

    task automatic program_settings(input int phase);
        logic [15:0] scale_pick;
        logic [15:0] gain_pick;
        scale_pick = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16, 1024));
        write_reg(CFG_TARGET_LEFT,
                  choose_setting(phase, 16'h0800, 16'h07FF, 16'($urandom), TARGET_W));
        write_reg(CFG_TARGET_RIGHT,
                  choose_setting(phase, 16'h0800, 16'h07FF, 16'($urandom), TARGET_W));
        write_reg(CFG_SPEED_SCALE,
                  choose_setting(phase, 16'h0000, 16'hFFFF, scale_pick, SCALE_W));
        gain_pick = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
        write_reg(CFG_PROP_GAIN, choose_setting(phase, 16'h0000, 16'hFFFF, gain_pick, GAIN_W));
        gain_pick = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
        write_reg(CFG_INTEG_GAIN, choose_setting(phase, 16'h0000, 16'hFFFF, gain_pick, GAIN_W));
        write_reg(CFG_EFFORT_LIMIT,
                  choose_setting(phase, 16'h0000, 16'h01FF, 16'($urandom_range(0, 511)), LIMIT_W));
        write_reg(CFG_SPARE_6, 16'($urandom));
        write_reg(CFG_SPARE_7, 16'($urandom));
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [15:0] pos_left;
        logic [15:0] pos_right;
        int          vel_left;
        int          vel_right;
        int          burst;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        enc_count_left <= '0;
        enc_count_right <= '0;
        restart <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_TARGET_LEFT;
        cfg_data <= '0;
        pressure_on <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first tick is measured against a count of zero; then full-range jumps and wraps.
        send_tick(16'd100, 16'hFF9C, 1'b0);
        send_tick(16'h7FFF, 16'h8000, 1'b0);
        send_tick(16'h8000, 16'h7FFF, 1'b0);
        send_tick(16'h0000, 16'h0000, 1'b0);
        send_tick(16'h0000, 16'h0000, 1'b1);
        wait_for_idle();

        write_reg(CFG_TARGET_LEFT, 16'h07FF);
        write_reg(CFG_TARGET_RIGHT, 16'hF800);
        write_reg(CFG_SPEED_SCALE, 16'hFFFF);
        write_reg(CFG_PROP_GAIN, 16'hFFFF);
        write_reg(CFG_INTEG_GAIN, 16'hFFFF);
        write_reg(CFG_EFFORT_LIMIT, 16'h01FF);
        write_reg(CFG_SPARE_6, 16'hFFFF);
        write_reg(CFG_SPARE_7, 16'h5A5A);
        cfg_write <= 1'b0;
        send_tick(16'd5, 16'hFFFB, 1'b0);
        send_tick(16'h7FFF, 16'h8000, 1'b0);
        send_tick(16'h0000, 16'h0000, 1'b0);
        send_tick(16'h0000, 16'h0000, 1'b1);
        send_tick(16'h0001, 16'h0001, 1'b0);
        send_tick(16'h0001, 16'h0001, 1'b0);
        wait_for_idle();

        write_reg(CFG_EFFORT_LIMIT, 16'hFE00);
        cfg_write <= 1'b0;
        send_tick(16'd100, 16'd200, 1'b0);
        send_tick(16'hFF9C, 16'h0000, 1'b1);
        wait_for_idle();

        write_reg(CFG_EFFORT_LIMIT, 16'd400);
        write_reg(CFG_INTEG_GAIN, 16'h0000);
        write_reg(CFG_PROP_GAIN, 16'h0100);
        write_reg(CFG_SPEED_SCALE, 16'h0100);
        cfg_write <= 1'b0;
        send_tick(16'd200, 16'hFF38, 1'b0);
        send_tick(16'd400, 16'hFE70, 1'b0);
        send_tick(16'd400, 16'hFE70, 1'b1);
        wait_for_idle();

        pos_left = 16'd400;
        pos_right = 16'hFE70;
        burst = $urandom_range(1, 40);
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_settings(phase);
            if (phase == 2)
                pressure_on <= 1'b1;
            vel_left = pick_velocity();
            vel_right = pick_velocity();
            for (int i = 0; i < TICKS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 49) == 0)
                    vel_left = pick_velocity();
                if ($urandom_range(0, 49) == 0)
                    vel_right = pick_velocity();
                if ($urandom_range(0, 99) < 8)
                    pos_left = 16'($urandom);
                else
                    pos_left = pos_left + 16'(vel_left + int'($urandom_range(0, 6)) - 3);
                if ($urandom_range(0, 99) < 8)
                    pos_right = 16'($urandom);
                else
                    pos_right = pos_right + 16'(vel_right + int'($urandom_range(0, 6)) - 3);
                send_tick(pos_left, pos_right, $urandom_range(0, 32) == 0);
                burst--;
                if (burst == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                    burst = $urandom_range(1, 40);
                end
            end
            wait_for_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
